// ----- rtl/core/hsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsa_pkg: handle slot allocator shared types and constants
// Request codes, beat payloads and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package hsa_pkg;

	// request codes
	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_LOOKUP  = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;
	localparam logic [1:0] REQ_POLL    = 2'd3;

	localparam int HANDLE_BASE = 3;   // handles 0..2 are reserved
	localparam int HANDLE_W    = 9;   // width of a returned handle
	localparam int FIELD_W     = 32;  // width of flag and token fields
	localparam int WORD_W      = 32;  // used-bit row width
	localparam int BIT_W       = 5;   // log2 of WORD_W

	typedef struct packed {
		logic [1:0]          req_type;
		logic signed [31:0]  handle_in;
		logic [FIELD_W-1:0]  flags_in;
		logic [FIELD_W-1:0]  ops_ref;
		logic [FIELD_W-1:0]  poll_ref;
		logic [FIELD_W-1:0]  ctx_ref;
	} req_t;

	typedef struct packed {
		logic                ok;
		logic [HANDLE_W-1:0] handle_out;
		logic [FIELD_W-1:0]  flags_out;
		logic [FIELD_W-1:0]  ops_ref_out;
		logic [FIELD_W-1:0]  poll_ref_out;
		logic [FIELD_W-1:0]  ctx_ref_out;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic clr_wr;   // clear one used-bit row
		logic load;     // capture request beat
		logic rd;       // issue table reads
		logic fail;     // result is a failure
		logic commit;   // finish request with read data
		logic advance;  // step scan to next row
		logic resp;     // move result into output register
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;  // clearing the last row
		logic alloc;     // held request is an alloc
		logic full;      // every slot in use
		logic hdl_ok;    // held handle names a slot
		logic found;     // free slot in row (alloc) or slot in use (others)
		logic out_free;  // output register can take a result
	} ctl_sts_t;

endpackage

// ----- rtl/core/hsa_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsa_chan_if: valid/ready channel
// Carries one payload beat per handshake.
// ----------------------------------------------------------------------------
interface hsa_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/hsa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsa_ctrl: request sequencer
// Clears the used-bit table after reset, then steps each request through
// read, evaluate and response.
// ----------------------------------------------------------------------------
module hsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hsa_pkg::ctl_sts_t sts,
	output hsa_pkg::ctl_cmd_t cmd
);
	import hsa_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				if ((sts.alloc && sts.full) || (!sts.alloc && !sts.hdl_ok)) begin
					cmd.fail = 1'b1;
					state_d  = S_RESP;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.alloc && !sts.found) begin
					cmd.advance = 1'b1;
					state_d     = S_READ;
				end else begin
					cmd.commit = 1'b1;
					state_d    = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.resp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/core/hsa_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsa_dpath: handle table datapath
// Used-bit rows, entry stores, next-fit row scan, handle decode and the
// output register.
// ----------------------------------------------------------------------------
module hsa_dpath #(
	parameter int SLOTS    = 256,
	parameter int REF_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hsa_pkg::req_t     in_data,
	input  hsa_pkg::ctl_cmd_t cmd,
	output hsa_pkg::ctl_sts_t sts,
	output logic              out_valid,
	input  logic              out_ready,
	output hsa_pkg::rsp_t     out_data
);
	import hsa_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ROWS   = (SLOTS + WORD_W - 1) / WORD_W;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SX_W   = ROW_W + BIT_W;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int HS_W   = (SX_W + 1 > HANDLE_W) ? SX_W + 1 : HANDLE_W;
	localparam int TAIL   = SLOTS % WORD_W;
	localparam logic [WORD_W-1:0] LAST_MASK =
		(TAIL == 0) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << TAIL) - 64'd1);
	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

	// held request and control registers
	req_t              req_q;
	logic [SLOT_W-1:0] start_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ROW_W-1:0]  scan_row_q;
	logic              first_q;
	logic [ROW_W-1:0]  clr_row_q;
	rsp_t              res_q;
	rsp_t              out_q;
	logic              out_valid_q;

	// tables
	logic [WORD_W-1:0]   used_mem [ROWS];
	logic [FIELD_W-1:0]  flags_mem [SLOTS];
	logic [REF_BITS-1:0] ops_mem [SLOTS];
	logic [REF_BITS-1:0] poll_mem [SLOTS];
	logic [REF_BITS-1:0] ctx_mem [SLOTS];
	logic [WORD_W-1:0]   used_rd_q;
	logic [FIELD_W-1:0]  flags_rd_q;
	logic [REF_BITS-1:0] ops_rd_q;
	logic [REF_BITS-1:0] poll_rd_q;
	logic [REF_BITS-1:0] ctx_rd_q;

	// decode and search signals
	logic [31:0]       h_raw;
	logic [31:0]       h_off;
	logic              hdl_ok;
	logic [SLOT_W-1:0] hdl_slot;
	logic [SX_W-1:0]   hdl_x;
	logic [ROW_W-1:0]  hdl_row;
	logic [BIT_W-1:0]  hdl_bit;
	logic [SX_W-1:0]   start_x;
	logic              is_alloc;
	logic              hit;
	logic [WORD_W-1:0] row_mask;
	logic [WORD_W-1:0] first_mask;
	logic [WORD_W-1:0] free_w;
	logic [BIT_W-1:0]  fnd_bit;
	logic [SX_W-1:0]   fnd_x;
	logic [SLOT_W-1:0] fnd_slot;
	logic [HS_W-1:0]   hsum;
	logic              used_we;
	logic [ROW_W-1:0]  used_wa;
	logic [WORD_W-1:0] used_wd;
	logic              data_we;
	logic              rel_hit;
	rsp_t              eval_res;

	assign is_alloc = (req_q.req_type == REQ_ALLOC);

	// handle to slot decode
	assign h_raw    = req_q.handle_in;
	assign h_off    = h_raw - 32'(HANDLE_BASE);
	assign hdl_ok   = !h_raw[31] && (h_raw >= 32'(HANDLE_BASE)) && (h_off < 32'(SLOTS));
	assign hdl_slot = h_off[SLOT_W-1:0];
	assign hdl_x    = SX_W'(hdl_slot);
	assign hdl_row  = hdl_x[SX_W-1:BIT_W];
	assign hdl_bit  = hdl_x[BIT_W-1:0];
	assign start_x  = SX_W'(start_q);
	assign hit      = used_rd_q[hdl_bit];

	// free bit search in the current row
	assign row_mask   = (scan_row_q == LAST_ROW) ? LAST_MASK : {WORD_W{1'b1}};
	assign first_mask = first_q ? ({WORD_W{1'b1}} << start_x[BIT_W-1:0]) : {WORD_W{1'b1}};
	assign free_w     = ~used_rd_q & row_mask & first_mask;

	always_comb begin
		fnd_bit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (free_w[i]) begin
				fnd_bit = BIT_W'(i);
			end
		end
	end

	assign fnd_x    = {scan_row_q, fnd_bit};
	assign fnd_slot = fnd_x[SLOT_W-1:0];
	assign hsum     = HS_W'(fnd_x) + HS_W'(HANDLE_BASE);

	// result of a finished request
	always_comb begin
		eval_res = '0;
		if (is_alloc) begin
			eval_res.ok         = 1'b1;
			eval_res.handle_out = hsum[HANDLE_W-1:0];
		end else if (hit) begin
			case (req_q.req_type)
				REQ_LOOKUP: begin
					eval_res.ok          = 1'b1;
					eval_res.flags_out   = flags_rd_q;
					eval_res.ops_ref_out = FIELD_W'(ops_rd_q);
					eval_res.ctx_ref_out = FIELD_W'(ctx_rd_q);
				end
				REQ_RELEASE: begin
					eval_res.ok = 1'b1;
				end
				REQ_POLL: begin
					if (poll_rd_q != '0) begin
						eval_res.ok           = 1'b1;
						eval_res.poll_ref_out = FIELD_W'(poll_rd_q);
						eval_res.ctx_ref_out  = FIELD_W'(ctx_rd_q);
					end
				end
				default: begin
					eval_res = '0;
				end
			endcase
		end
	end

	// used-bit row write port
	assign rel_hit = cmd.commit && !is_alloc && (req_q.req_type == REQ_RELEASE) && hit;
	assign used_we = cmd.clr_wr || (cmd.commit && is_alloc) || rel_hit;
	assign data_we = cmd.commit && is_alloc;

	always_comb begin
		if (cmd.clr_wr) begin
			used_wa = clr_row_q;
			used_wd = '0;
		end else if (is_alloc) begin
			used_wa = scan_row_q;
			used_wd = used_rd_q | (WORD_W'(1) << fnd_bit);
		end else begin
			used_wa = hdl_row;
			used_wd = used_rd_q & ~(WORD_W'(1) << hdl_bit);
		end
	end

	// used-bit table
	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[used_wa] <= used_wd;
		end
		if (cmd.rd) begin
			used_rd_q <= used_mem[is_alloc ? scan_row_q : hdl_row];
		end
	end

	// entry stores
	always_ff @(posedge clk) begin
		if (data_we) begin
			flags_mem[fnd_slot] <= req_q.flags_in;
			ops_mem[fnd_slot]   <= REF_BITS'(req_q.ops_ref);
			poll_mem[fnd_slot]  <= REF_BITS'(req_q.poll_ref);
			ctx_mem[fnd_slot]   <= REF_BITS'(req_q.ctx_ref);
		end
		if (cmd.rd && !is_alloc) begin
			flags_rd_q <= flags_mem[hdl_slot];
			ops_rd_q   <= ops_mem[hdl_slot];
			poll_rd_q  <= poll_mem[hdl_slot];
			ctx_rd_q   <= ctx_mem[hdl_slot];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data;
		end
		if (cmd.fail) begin
			res_q <= '0;
		end else if (cmd.commit) begin
			res_q <= eval_res;
		end
		if (cmd.resp) begin
			out_q <= res_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '0;
			cnt_q       <= '0;
			scan_row_q  <= '0;
			first_q     <= 1'b0;
			clr_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_row_q <= clr_row_q + 1'b1;
			end
			if (cmd.load) begin
				scan_row_q <= start_x[SX_W-1:BIT_W];
				first_q    <= 1'b1;
			end else if (cmd.advance) begin
				scan_row_q <= (scan_row_q == LAST_ROW) ? '0 : scan_row_q + 1'b1;
				first_q    <= 1'b0;
			end
			if (data_we) begin
				start_q <= (fnd_slot == SLOT_LAST) ? '0 : fnd_slot + 1'b1;
				cnt_q   <= cnt_q + 1'b1;
			end else if (rel_hit) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.resp) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// status to the controller
	assign sts.clr_last = (clr_row_q == LAST_ROW);
	assign sts.alloc    = is_alloc;
	assign sts.full     = (cnt_q == CNT_FULL);
	assign sts.hdl_ok   = hdl_ok;
	assign sts.found    = is_alloc ? (|free_w) : hit;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/core/handle_slot_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_slot_allocator_top: next-fit handle table allocator
//
//   Channel  Dir  Payload  Beat
//   req      in   req_t    one request: alloc, lookup, release or poll query
//   rsp      out  rsp_t    one result per request, in request order
//
// A lookup, release or poll query is taken in S_IDLE, reads tables in S_READ,
// is evaluated in S_EVAL and in S_RESP loads its result into the output
// register. A failed request (bad handle, or alloc on a full table) goes from
// S_READ straight to S_RESP. An alloc repeats the row read (S_READ) and
// evaluation (S_EVAL) for each 32-slot used-bit row scanned until a free slot
// is found. req.ready comes back the cycle after the result is loaded; no new
// request is taken before then. After reset a clearing pass writes the used-bit
// rows with req.ready low. A stalled result sits in the output register while
// the next request is taken; the result after it waits with req.ready low.
// ----------------------------------------------------------------------------
module handle_slot_allocator_top #(
	parameter int SLOTS    = 256,
	parameter int REF_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	hsa_chan_if.sink   req,
	hsa_chan_if.source rsp
);
	import hsa_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	hsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hsa_dpath #(
		.SLOTS    (SLOTS),
		.REF_BITS (REF_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (rsp.data)
	);

`ifndef SYNTHESIS
	// commands are mutually exclusive
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.load, cmd.rd, cmd.fail, cmd.commit, cmd.advance, cmd.resp}))
		else $error("more than one datapath command at once");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp |-> sts.out_free)
		else $error("result loaded over an untaken result");

	// an alloc only completes on a free slot
	a_alloc_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && sts.alloc) |-> sts.found)
		else $error("alloc committed without a free slot");

	// the row scan only runs while a slot is free
	a_scan_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> !sts.full)
		else $error("scan advanced on a full table");
`endif

endmodule
